// File: src/mmc_pkg.sv
// Shared definitions for the multi-mode checksum engine: mode codes,
// register indexes, CRC polynomials and initial values.
// No dependencies.
`default_nettype none

package mmc_pkg;

    // Field and register widths
    localparam int DATA_W = 8;
    localparam int ACC_W  = 32;
    localparam int MODE_W = 3;
    localparam int LEN_W  = 3;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 3;

    // Checksum mode codes
    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUM8  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_XOR8  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CRC8  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CRC16 = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CRC32 = 3'd5;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_LEN  = 2'd1;

    // Result length codes
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;

    // Polynomials and seeds
    localparam logic [7:0]       POLY_CRC8  = 8'h07;
    localparam logic [15:0]      POLY_CRC16 = 16'hA001;
    localparam logic [ACC_W-1:0] POLY_CRC32 = 32'hEDB8_8320;
    localparam logic [ACC_W-1:0] INIT_CRC16 = 32'h0000_FFFF;
    localparam logic [ACC_W-1:0] INIT_CRC32 = 32'hFFFF_FFFF;

    // Seed of the accumulator for a given mode
    function automatic logic [ACC_W-1:0] mode_initial(input logic [MODE_W-1:0] mode);
        logic [ACC_W-1:0] init;
        case (mode)
            MODE_CRC16: init = INIT_CRC16;
            MODE_CRC32: init = INIT_CRC32;
            default:    init = '0;
        endcase
        return init;
    endfunction

endpackage

`default_nettype wire

// File: src/mmc_fold.sv
// Combinational fold of one message byte into the running accumulator,
// plus the finished, length-masked checksum for a last byte.
// Depends on mmc_pkg.
`default_nettype none

module mmc_fold (
    input  wire logic [mmc_pkg::ACC_W-1:0]  i_acc,
    input  wire logic [mmc_pkg::MODE_W-1:0] i_mode,
    input  wire logic [mmc_pkg::LEN_W-1:0]  i_len,
    input  wire logic [mmc_pkg::DATA_W-1:0] i_byte,
    output logic      [mmc_pkg::ACC_W-1:0]  o_acc_next,
    output logic      [mmc_pkg::ACC_W-1:0]  o_checksum
);
    import mmc_pkg::*;

    logic [7:0]       crc8;
    logic [15:0]      crc16;
    logic [ACC_W-1:0] crc32;
    logic [ACC_W-1:0] raw;
    logic [ACC_W-1:0] len_mask;

    // Unroll the eight bit steps of each CRC
    always_comb begin
        crc8  = i_acc[7:0] ^ i_byte;
        crc16 = i_acc[15:0] ^ {8'h00, i_byte};
        crc32 = i_acc ^ {{(ACC_W-DATA_W){1'b0}}, i_byte};
        for (int i = 0; i < DATA_W; i++) begin
            crc8  = crc8[7] ? ({crc8[6:0], 1'b0} ^ POLY_CRC8) : {crc8[6:0], 1'b0};
            crc16 = crc16[0] ? ({1'b0, crc16[15:1]} ^ POLY_CRC16) : {1'b0, crc16[15:1]};
            crc32 = crc32[0] ? ({1'b0, crc32[ACC_W-1:1]} ^ POLY_CRC32)
                             : {1'b0, crc32[ACC_W-1:1]};
        end
    end

    // Select the next accumulator by mode; unused codes hold zero
    always_comb begin
        case (i_mode)
            MODE_SUM8:  o_acc_next = {24'h0, i_acc[7:0] + i_byte};
            MODE_XOR8:  o_acc_next = {24'h0, i_acc[7:0] ^ i_byte};
            MODE_CRC8:  o_acc_next = {24'h0, crc8};
            MODE_CRC16: o_acc_next = {16'h0, crc16};
            MODE_CRC32: o_acc_next = crc32;
            default:    o_acc_next = '0;
        endcase
    end

    // Finish the checksum from the updated accumulator
    always_comb begin
        case (i_mode)
            MODE_SUM8, MODE_XOR8, MODE_CRC8: raw = {24'h0, o_acc_next[7:0]};
            MODE_CRC16: raw = {16'h0, o_acc_next[15:0]};
            MODE_CRC32: raw = ~o_acc_next;
            default:    raw = '0;
        endcase
    end

    // Keep only the configured number of bytes; zero acts as one
    always_comb begin
        case (i_len)
            3'd0, LEN_ONE: len_mask = 32'h0000_00FF;
            LEN_TWO:       len_mask = 32'h0000_FFFF;
            LEN_THREE:     len_mask = 32'h00FF_FFFF;
            default:       len_mask = 32'hFFFF_FFFF;
        endcase
    end

    assign o_checksum = raw & len_mask;

endmodule

`default_nettype wire

// File: src/multi_mode_checksum.sv
// Top level of the multi-mode checksum engine: input register, running
// accumulator, result register and configuration registers.
// Depends on mmc_pkg and mmc_fold.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] data_byte, tlast last_byte
//   m_axis    out        tdata[31:0] checksum_value (one item per last byte)
//   cfg       in         index 0 checksum_mode, index 1 result_length
//
// One byte per cycle; bytes and results are registered. The byte fold is one
// combinational pass between the input register and the accumulator.
// Reset (synchronous, active low) sets mode none, length one, accumulator 0.
// A last byte waits in the input register while the result register is full
// and not taken; other bytes pass regardless of the output side.
`default_nettype none

module multi_mode_checksum (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Input stream
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [mmc_pkg::DATA_W-1:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic                        i_s_axis_tlast,   // last_byte
    // Result stream
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic      [mmc_pkg::ACC_W-1:0]   o_m_axis_tdata,   // [31:0] checksum_value
    // Configuration writes
    input  wire logic                        i_cfg_we,
    input  wire logic [mmc_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [mmc_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import mmc_pkg::*;

    logic                r_in_valid;
    logic [DATA_W-1:0]   r_in_byte;
    logic                r_in_last;
    logic [ACC_W-1:0]    r_acc;
    logic [MODE_W-1:0]   r_mode;
    logic [LEN_W-1:0]    r_len;
    logic                r_out_valid;
    logic [ACC_W-1:0]    r_out_data;
    logic [ACC_W-1:0]    n_acc;
    logic [ACC_W-1:0]    checksum;
    logic                out_free;
    logic                fire;

    mmc_fold u_fold (
        .i_acc      (r_acc),
        .i_mode     (r_mode),
        .i_len      (r_len),
        .i_byte     (r_in_byte),
        .o_acc_next (n_acc),
        .o_checksum (checksum)
    );

    // Process the held item unless it needs a result slot that is taken
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Load the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Update configuration and accumulator; a mode write reseeds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
            r_len  <= LEN_ONE;
            r_acc  <= '0;
        end else if (i_cfg_we && i_cfg_index == REG_MODE) begin
            r_mode <= i_cfg_wdata;
            r_acc  <= mode_initial(i_cfg_wdata);
        end else begin
            if (i_cfg_we && i_cfg_index == REG_LEN) begin
                r_len <= i_cfg_wdata;
            end
            if (fire) begin
                r_acc <= r_in_last ? mode_initial(r_mode) : n_acc;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (fire && r_in_last) begin
            r_out_data <= checksum;
        end
    end

endmodule

`default_nettype wire
